/* src/b64_pkg.sv */
// Shared types, constants and the alphabet lookup for the Base64 stream decoder.
package b64_pkg;

  localparam logic [7:0] PadChar = 8'h3D;
  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic [7:0] code_char;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       bad_input;
    logic       run_last;
    logic       message_done;
  } out_item_t;

  typedef struct packed {
    logic [1:0]                     count;
    out_item_t [MaxResults-1:0]     res;
  } res_group_t;

  // Returns {invalid, sextet}; the pad character maps to a zero sextet.
  function automatic logic [6:0] map_char(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c inside {[8'h41:8'h5A]}) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b0, 6'd63};
    end else if (c == PadChar) begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage

/* src/base64_stream_decoder_top.sv */
// Top level of the Base64 stream decoder: input register, decode and result queue.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i) takes one text
//   character per request, with message_end set on the final character.
//   Output channel (out_valid_o / out_ready_i / out_item_o) gives decoded
//   bytes, an error result where a group fails, and a closing marker where
//   the end character gives no other result (bad_input in a failed message);
//   run_last and message_done flag the last result of a character and of a message.
//   The first result of a character is presented from the result queue
//   register, after the character has passed the input register.
//   Throughput: one character per cycle while the queue has room; a group
//   of four characters gives at most three results. A character whose
//   results meet an earlier group still draining holds the input until
//   the queue frees.
//   Characters that give no result pass without waiting on the output.
//   Reset clears all group and message state and drops any held results.
//   When the receiver stalls, the result queue and the input register fill
//   and in_ready_o falls; nothing is lost.
module base64_stream_decoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  b64_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b64_pkg::out_item_t  out_item_o
);

  b64_pkg::in_item_t   item_q;
  logic                valid_q;
  b64_pkg::res_group_t group;
  logic                space;
  logic                consume;
  logic                load;

  assign consume    = valid_q && (group.count == 2'd0 || space);
  assign load       = consume && (group.count != 2'd0);
  assign in_ready_o = !valid_q || consume;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (consume) begin
      valid_q <= 1'b0;
    end
  end

  b64_group_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_q),
    .step_i  (consume),
    .group_o (group)
  );

  b64_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .group_i     (group),
    .load_i      (load),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* src/b64_group_decode.sv */
// Group state and per-character decode into a group of up to three results.
module b64_group_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  b64_pkg::in_item_t    item_i,
  input  logic                 step_i,
  output b64_pkg::res_group_t  group_o
);

  logic [17:0] hold_q, hold_d;
  logic [1:0]  count_q, count_d;
  logic        ginv_q, ginv_d;
  logic        tpad_q, tpad_d;
  logic        failed_q, failed_d;

  logic [6:0]  mapped;
  logic [5:0]  sextet;
  logic [23:0] word;
  logic        is_pad;
  logic [1:0]  n;
  b64_pkg::out_item_t [b64_pkg::MaxResults-1:0] res;

  assign mapped = b64_pkg::map_char(item_i.code_char);
  assign sextet = mapped[6] ? 6'd0 : mapped[5:0];
  assign word   = {hold_q, sextet};
  assign is_pad = (item_i.code_char == b64_pkg::PadChar);

  always_comb begin
    hold_d   = hold_q;
    count_d  = count_q;
    ginv_d   = ginv_q;
    tpad_d   = tpad_q;
    failed_d = failed_q;
    n        = 2'd0;
    res      = '0;
    if (!failed_q) begin
      if (count_q != 2'd3) begin
        hold_d  = {hold_q[11:0], sextet};
        ginv_d  = ginv_q | mapped[6];
        count_d = count_q + 2'd1;
        if (count_q == 2'd2) begin
          tpad_d = is_pad;
        end
      end else begin
        if (ginv_q || mapped[6]) begin
          res[0].bad_input = 1'b1;
          n        = 2'd1;
          failed_d = 1'b1;
        end else begin
          res[0].data_byte  = word[23:16];
          res[0].byte_valid = 1'b1;
          n = 2'd1;
          if (!tpad_q) begin
            res[1].data_byte  = word[15:8];
            res[1].byte_valid = 1'b1;
            n = 2'd2;
            if (!is_pad) begin
              res[2].data_byte  = word[7:0];
              res[2].byte_valid = 1'b1;
              n = 2'd3;
            end
          end
        end
        hold_d  = '0;
        count_d = 2'd0;
        ginv_d  = 1'b0;
        tpad_d  = 1'b0;
      end
    end
    if (item_i.message_end) begin
      if (n == 2'd0) begin
        res[0].bad_input = failed_q;
        n = 2'd1;
      end
      for (int i = 0; i < b64_pkg::MaxResults; i++) begin
        if (2'(i) == n - 2'd1) begin
          res[i].message_done = 1'b1;
        end
      end
      hold_d   = '0;
      count_d  = 2'd0;
      ginv_d   = 1'b0;
      tpad_d   = 1'b0;
      failed_d = 1'b0;
    end
    for (int i = 0; i < b64_pkg::MaxResults; i++) begin
      if (n != 2'd0 && 2'(i) == n - 2'd1) begin
        res[i].run_last = 1'b1;
      end
    end
  end

  assign group_o.count = n;
  assign group_o.res   = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q   <= '0;
      count_q  <= '0;
      ginv_q   <= 1'b0;
      tpad_q   <= 1'b0;
      failed_q <= 1'b0;
    end else if (step_i) begin
      hold_q   <= hold_d;
      count_q  <= count_d;
      ginv_q   <= ginv_d;
      tpad_q   <= tpad_d;
      failed_q <= failed_d;
    end
  end

`ifndef SYNTHESIS
  a_failed_holds_group_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> (count_q == 2'd0 && !ginv_q))
    else $error("group state not cleared while message is swallowed");
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.message_end) |=> (count_q == 2'd0 && !failed_q))
    else $error("state not cleared after message end");
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.message_end) |-> (group_o.count != 2'd0))
    else $error("message end without a result");
`endif

endmodule

/* src/b64_result_queue.sv */
// Result group register that hands out one result per output request.
module b64_result_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  b64_pkg::res_group_t  group_i,
  input  logic                 load_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output b64_pkg::out_item_t   out_item_o
);

  b64_pkg::out_item_t [b64_pkg::MaxResults-1:0] res_q;
  logic [1:0] cnt_q;
  logic [1:0] idx_q;
  logic       valid_q;
  logic       take;
  logic       last_take;

  assign out_valid_o = valid_q;
  assign out_item_o  = res_q[idx_q];
  assign take        = valid_q && out_ready_i;
  assign last_take   = take && (idx_q == cnt_q - 2'd1);
  assign space_o     = !valid_q || last_take;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= group_i.res;
      cnt_q <= group_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (last_take) begin
      valid_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_load_needs_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> space_o)
    else $error("result group overwritten");
  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (valid_q && idx_q == 2'd0))
    else $error("loaded group not presented from its first result");
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (cnt_q != 2'd0 && idx_q < cnt_q))
    else $error("result index beyond group");
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_take |-> out_item_o.run_last)
    else $error("group closed without run_last");
`endif

endmodule
